[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// Shorthand for clocked concurrent assertions with a synchronous active-low
// reset that disables the check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[src/pwl_pkg.sv]
// ----------------------------------------------------------------------------
// pwl_pkg
// Types, codes and the control store of the piecewise linear scale block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pwl_pkg;

    // field widths
    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 5;
    localparam int LAYOUT_W   = 2;
    localparam int INDEX_W    = 4;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;
    localparam int ENTRY_W    = 3 * VALUE_W;

    // divider iteration counter
    localparam int                DIV_CNT_W = $clog2(VALUE_W);
    localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST = DIV_CNT_W'(VALUE_W - 1);

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_POINT_COUNT  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_VALUE_LAYOUT = 1'b1;

    // value layouts
    localparam logic [LAYOUT_W-1:0] LAYOUT_PER_POINT = 2'd2;
    localparam logic [LAYOUT_W-1:0] LAYOUT_SPLIT     = 2'd3;

    // register reset values
    localparam logic [COUNT_W-1:0]  POINT_COUNT_RESET  = 5'd1;
    localparam logic [LAYOUT_W-1:0] VALUE_LAYOUT_RESET = LAYOUT_PER_POINT;

    // input operations
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // sequencer steps
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_ABS,
        ST_MUL,
        ST_DIV,
        ST_SUM,
        ST_OUT
    } step_t;

    // datapath operations
    typedef enum logic [2:0] {
        DP_IDLE,
        DP_SCAN,
        DP_DECIDE,
        DP_ABS,
        DP_MUL,
        DP_DIV,
        DP_SUM,
        DP_OUT
    } dp_op_t;

    // jump conditions
    typedef enum logic [2:0] {
        JC_NEVER,
        JC_EVAL_ACCEPT,
        JC_SCAN_LAST,
        JC_NO_INTERP,
        JC_DIV_DONE,
        JC_OUT_FREE
    } jump_cond_t;

    // one control word: operation, jump condition and target, and whether
    // the step repeats when the condition is false
    typedef struct packed {
        dp_op_t     op;
        jump_cond_t cond;
        step_t      target;
        logic       hold;
    } ucode_t;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic eval_accept;
        logic scan_last;
        logic no_interp;
        logic div_done;
        logic out_free;
    } dp_flags_t;

    // table mode derived from configuration
    typedef struct packed {
        logic const_mode;
        logic split_mode;
    } mode_t;

    // control store
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        unique case (step)
            ST_IDLE:   w = '{op: DP_IDLE,   cond: JC_EVAL_ACCEPT, target: ST_SCAN,   hold: 1'b1};
            ST_SCAN:   w = '{op: DP_SCAN,   cond: JC_SCAN_LAST,   target: ST_DECIDE, hold: 1'b1};
            ST_DECIDE: w = '{op: DP_DECIDE, cond: JC_NO_INTERP,   target: ST_OUT,    hold: 1'b0};
            ST_ABS:    w = '{op: DP_ABS,    cond: JC_NEVER,       target: ST_IDLE,   hold: 1'b0};
            ST_MUL:    w = '{op: DP_MUL,    cond: JC_NEVER,       target: ST_IDLE,   hold: 1'b0};
            ST_DIV:    w = '{op: DP_DIV,    cond: JC_DIV_DONE,    target: ST_SUM,    hold: 1'b1};
            ST_SUM:    w = '{op: DP_SUM,    cond: JC_NEVER,       target: ST_IDLE,   hold: 1'b0};
            ST_OUT:    w = '{op: DP_OUT,    cond: JC_OUT_FREE,    target: ST_IDLE,   hold: 1'b1};
        endcase
        return w;
    endfunction

endpackage

[src/pwl_ram.sv]
// ----------------------------------------------------------------------------
// pwl_ram
// Generic simple dual-port RAM, one write port, one read port with
// registered read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/pwl_sequencer.sv]
// ----------------------------------------------------------------------------
// pwl_sequencer
// Step counter over the control store, with conditional jumps on datapath
// status. Drives the datapath operation of each step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwl_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  pwl_pkg::dp_flags_t  flags,
    output pwl_pkg::dp_op_t     op
);

    pwl_pkg::step_t  step_reg;
    pwl_pkg::step_t  step_next;
    pwl_pkg::ucode_t uword;
    logic            cond_hit;

    // step register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= pwl_pkg::ST_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    // control word fetch, condition select and next step
    always_comb begin
        uword = pwl_pkg::ucode_rom(step_reg);
        unique case (uword.cond)
            pwl_pkg::JC_NEVER:       cond_hit = 1'b0;
            pwl_pkg::JC_EVAL_ACCEPT: cond_hit = flags.eval_accept;
            pwl_pkg::JC_SCAN_LAST:   cond_hit = flags.scan_last;
            pwl_pkg::JC_NO_INTERP:   cond_hit = flags.no_interp;
            pwl_pkg::JC_DIV_DONE:    cond_hit = flags.div_done;
            pwl_pkg::JC_OUT_FREE:    cond_hit = flags.out_free;
            default:                 cond_hit = 1'b0;
        endcase
        if (cond_hit) begin
            step_next = uword.target;
        end else if (uword.hold) begin
            step_next = step_reg;
        end else begin
            step_next = pwl_pkg::step_t'(step_reg + 3'd1);
        end
        op = uword.op;
    end

endmodule

[src/pwl_datapath.sv]
// ----------------------------------------------------------------------------
// pwl_datapath
// Breakpoint table, segment scan registers, magnitude/multiply unit,
// restoring divider, saturating sum and the output register. Each step
// performs the operation given by the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwl_datapath #(
    parameter int MAX_POINTS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pwl_pkg::dp_op_t                   op,
    output pwl_pkg::dp_flags_t                flags,
    input  pwl_pkg::mode_t                    mode,
    input  logic [$clog2(MAX_POINTS)-1:0]     last_idx,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_operation,
    input  logic [pwl_pkg::INDEX_W-1:0]       s_point_index,
    input  logic signed [pwl_pkg::VALUE_W-1:0] s_point_position,
    input  logic signed [pwl_pkg::VALUE_W-1:0] s_left_scale,
    input  logic signed [pwl_pkg::VALUE_W-1:0] s_right_scale,
    input  logic signed [pwl_pkg::VALUE_W-1:0] s_sample,
    input  logic                              s_row_end,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [pwl_pkg::VALUE_W-1:0] m_scale_value
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int W     = pwl_pkg::VALUE_W;
    localparam int EW    = pwl_pkg::ENTRY_W;
    localparam int CW    = pwl_pkg::DIV_CNT_W;

    // table port
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [EW-1:0]    ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [EW-1:0]    ram_rdata;

    // entry on the read port
    logic signed [W-1:0] cur_pos;
    logic signed [W-1:0] cur_left;
    logic signed [W-1:0] cur_right;

    // handshake
    logic in_fire;
    logic load_fire;
    logic eval_fire;
    logic idx_ok;
    logic out_free;

    // scan compares
    logic is_first;
    logic is_last;
    logic below_cur;
    logic in_seg;
    logic at_cur;

    // divider and sum
    logic [W:0]            rem_sh;
    logic                  div_ge;
    logic [W:0]            rem_new;
    logic [W:0]            mag_full;
    logic signed [W+1:0]   s1_ext;
    logic signed [W+1:0]   q_ext;
    logic signed [W+1:0]   sum_val;
    logic [W-1:0]          sat_val;

    // registers
    logic signed [W-1:0] sample_reg,     sample_next;
    logic                row_end_reg,    row_end_next;
    logic [IDX_W-1:0]    cur_idx_reg,    cur_idx_next;
    logic signed [W-1:0] prev_pos_reg,   prev_pos_next;
    logic signed [W-1:0] prev_left_reg,  prev_left_next;
    logic signed [W-1:0] prev_right_reg, prev_right_next;
    logic                seg_found_reg,  seg_found_next;
    logic                last_hit_reg,   last_hit_next;
    logic signed [W-1:0] s1_reg,         s1_next;
    logic signed [W-1:0] s2_reg,         s2_next;
    logic signed [W-1:0] p1_reg,         p1_next;
    logic signed [W-1:0] p2_reg,         p2_next;
    logic signed [W-1:0] res_reg,        res_next;
    logic signed [W:0]   ds_reg,         ds_next;
    logic [W-1:0]        dist_reg,       dist_next;
    logic [W-1:0]        offs_reg,       offs_next;
    logic [W-1:0]        mag_reg,        mag_next;
    logic                neg_reg,        neg_next;
    logic [2*W-1:0]      div_reg,        div_next;
    logic [CW-1:0]       div_cnt_reg,    div_cnt_next;
    logic                m_valid_reg,    m_valid_next;
    logic signed [W-1:0] m_data_reg,     m_data_next;

    // breakpoint table, one row holds position, left and right value
    pwl_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cur_pos   = ram_rdata[3*W-1:2*W];
    assign cur_left  = ram_rdata[2*W-1:W];
    assign cur_right = ram_rdata[W-1:0];

    // input handshake, loads are written straight into the table
    assign s_ready   = (op == pwl_pkg::DP_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign load_fire = in_fire && (s_operation == pwl_pkg::OP_LOAD);
    assign eval_fire = in_fire && (s_operation == pwl_pkg::OP_EVAL);
    assign idx_ok    = 32'(s_point_index) < 32'(MAX_POINTS);
    assign ram_we    = load_fire && idx_ok;
    assign ram_waddr = IDX_W'(s_point_index);
    assign ram_wdata = {s_point_position, s_left_scale, s_right_scale};

    // read one row ahead while scanning, row zero while idle
    assign ram_raddr = (op == pwl_pkg::DP_SCAN) ? cur_idx_reg + IDX_W'(1) : '0;

    // scan compares
    assign is_first  = (cur_idx_reg == '0);
    assign is_last   = (cur_idx_reg == last_idx);
    assign below_cur = (sample_reg < cur_pos);
    assign in_seg    = (sample_reg >= prev_pos_reg) && below_cur;
    assign at_cur    = (sample_reg == cur_pos);

    // restoring divide step: quotient bits shift into the low half
    assign rem_sh  = div_reg[2*W-1:W-1];
    assign div_ge  = (rem_sh >= {1'b0, dist_reg});
    assign rem_new = div_ge ? rem_sh - {1'b0, dist_reg} : rem_sh;

    // magnitude of the value step
    assign mag_full = ds_reg[W] ? -ds_reg : ds_reg;

    // start value plus signed quotient, saturated
    assign s1_ext  = (W+2)'(s1_reg);
    assign q_ext   = {2'b00, div_reg[W-1:0]};
    assign sum_val = neg_reg ? s1_ext - q_ext : s1_ext + q_ext;
    always_comb begin
        if ((sum_val[W+1:W-1] == '0) || (sum_val[W+1:W-1] == '1)) begin
            sat_val = sum_val[W-1:0];
        end else begin
            sat_val = {sum_val[W+1], {(W-1){~sum_val[W+1]}}};
        end
    end

    // status to the sequencer
    assign out_free          = !m_valid_reg || m_ready;
    assign flags.eval_accept = eval_fire;
    assign flags.scan_last   = is_last;
    assign flags.no_interp   = last_hit_reg || !seg_found_reg || (s1_reg == s2_reg);
    assign flags.div_done    = (div_cnt_reg == pwl_pkg::DIV_CNT_LAST);
    assign flags.out_free    = out_free;

    // next-state logic for each step
    always_comb begin
        sample_next     = sample_reg;
        row_end_next    = row_end_reg;
        cur_idx_next    = cur_idx_reg;
        prev_pos_next   = prev_pos_reg;
        prev_left_next  = prev_left_reg;
        prev_right_next = prev_right_reg;
        seg_found_next  = seg_found_reg;
        last_hit_next   = last_hit_reg;
        s1_next         = s1_reg;
        s2_next         = s2_reg;
        p1_next         = p1_reg;
        p2_next         = p2_reg;
        res_next        = res_reg;
        ds_next         = ds_reg;
        dist_next       = dist_reg;
        offs_next       = offs_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        div_next        = div_reg;
        div_cnt_next    = div_cnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        unique case (op)
            pwl_pkg::DP_IDLE: begin
                if (eval_fire) begin
                    sample_next    = s_sample;
                    row_end_next   = s_row_end;
                    cur_idx_next   = '0;
                    seg_found_next = 1'b0;
                    last_hit_next  = 1'b0;
                    res_next       = '0;
                end
            end
            pwl_pkg::DP_SCAN: begin
                cur_idx_next    = cur_idx_reg + IDX_W'(1);
                prev_pos_next   = cur_pos;
                prev_left_next  = cur_left;
                prev_right_next = cur_right;
                // below the first point, or the constant layout
                if (is_first) begin
                    if (mode.const_mode || below_cur) begin
                        res_next = cur_left;
                    end
                end else if (!mode.const_mode && in_seg) begin
                    // the latest matching segment wins
                    seg_found_next = 1'b1;
                    s1_next        = mode.split_mode ? prev_right_reg : prev_left_reg;
                    s2_next        = cur_left;
                    p1_next        = prev_pos_reg;
                    p2_next        = cur_pos;
                end
                // at or beyond the last point overrides everything
                if (is_last && !mode.const_mode && !below_cur) begin
                    last_hit_next = 1'b1;
                    if (mode.split_mode && !(row_end_reg && at_cur && !is_first)) begin
                        res_next = cur_right;
                    end else begin
                        res_next = cur_left;
                    end
                end
            end
            pwl_pkg::DP_DECIDE: begin
                ds_next   = (W+1)'(s2_reg) - (W+1)'(s1_reg);
                dist_next = p2_reg - p1_reg;
                offs_next = sample_reg - p1_reg;
                // flat segment needs no interpolation
                if (seg_found_reg && !last_hit_reg && (s1_reg == s2_reg)) begin
                    res_next = s1_reg;
                end
            end
            pwl_pkg::DP_ABS: begin
                mag_next = mag_full[W-1:0];
                neg_next = ds_reg[W];
            end
            pwl_pkg::DP_MUL: begin
                div_next     = (2*W)'(mag_reg) * (2*W)'(offs_reg);
                div_cnt_next = '0;
            end
            pwl_pkg::DP_DIV: begin
                div_next     = {rem_new[W-1:0], div_reg[W-2:0], div_ge};
                div_cnt_next = div_cnt_reg + CW'(1);
            end
            pwl_pkg::DP_SUM: begin
                res_next = sat_val;
            end
            pwl_pkg::DP_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_idx_reg   <= '0;
            seg_found_reg <= 1'b0;
            last_hit_reg  <= 1'b0;
            div_cnt_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_idx_reg   <= cur_idx_next;
            seg_found_reg <= seg_found_next;
            last_hit_reg  <= last_hit_next;
            div_cnt_reg   <= div_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        sample_reg     <= sample_next;
        row_end_reg    <= row_end_next;
        prev_pos_reg   <= prev_pos_next;
        prev_left_reg  <= prev_left_next;
        prev_right_reg <= prev_right_next;
        s1_reg         <= s1_next;
        s2_reg         <= s2_next;
        p1_reg         <= p1_next;
        p2_reg         <= p2_next;
        res_reg        <= res_next;
        ds_reg         <= ds_next;
        dist_reg       <= dist_next;
        offs_reg       <= offs_next;
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        div_reg        <= div_next;
        m_data_reg     <= m_data_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_scale_value = m_data_reg;

endmodule

[src/piecewise_linear_scale_function.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_scale_function
// Load transactions write breakpoint rows (position, left and right scale);
// evaluate transactions return one saturated Q16.16 scale value each. Loads
// are taken every cycle while the block is idle. An evaluate scans the table
// one row per cycle from the single read port of the table RAM, then forms
// the differences. When no interpolation is needed (below the first point,
// flat segment, last point, constant layout) the result goes straight to
// the output step; when it is, the magnitude, a 32 x 32 multiply, the
// bit-serial divider and the saturating sum come first. The next transaction
// is accepted the cycle after the result enters the output register, which
// holds it while the consumer stalls. Configuration writes are accepted
// every cycle and must only happen while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module piecewise_linear_scale_function #(
    parameter int MAX_POINTS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pwl_pkg::CFG_ADDR_W-1:0]     cfg_index,
    input  logic [pwl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_operation,
    input  logic [pwl_pkg::INDEX_W-1:0]        s_point_index,
    input  logic signed [pwl_pkg::VALUE_W-1:0] s_point_position,
    input  logic signed [pwl_pkg::VALUE_W-1:0] s_left_scale,
    input  logic signed [pwl_pkg::VALUE_W-1:0] s_right_scale,
    input  logic signed [pwl_pkg::VALUE_W-1:0] s_sample,
    input  logic                               s_row_end,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [pwl_pkg::VALUE_W-1:0] m_scale_value
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int NW    = (pwl_pkg::COUNT_W > $clog2(MAX_POINTS + 1)) ?
                           pwl_pkg::COUNT_W : $clog2(MAX_POINTS + 1);

    logic [pwl_pkg::COUNT_W-1:0]  count_reg,  count_next;
    logic [pwl_pkg::LAYOUT_W-1:0] layout_reg, layout_next;
    logic [NW-1:0]                count_ext;
    logic [IDX_W-1:0]             last_idx;
    pwl_pkg::mode_t               mode;
    pwl_pkg::dp_op_t              op;
    pwl_pkg::dp_flags_t           flags;

    // configuration register writes
    assign cfg_ready = 1'b1;

    always_comb begin
        count_next  = count_reg;
        layout_next = layout_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                pwl_pkg::REG_POINT_COUNT:  count_next  = cfg_data[pwl_pkg::COUNT_W-1:0];
                pwl_pkg::REG_VALUE_LAYOUT: layout_next = cfg_data[pwl_pkg::LAYOUT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= pwl_pkg::POINT_COUNT_RESET;
            layout_reg <= pwl_pkg::VALUE_LAYOUT_RESET;
        end else begin
            count_reg  <= count_next;
            layout_reg <= layout_next;
        end
    end

    // layout decode; layouts zero and one use a single constant
    assign mode.const_mode = (layout_reg < pwl_pkg::LAYOUT_PER_POINT);
    assign mode.split_mode = (layout_reg == pwl_pkg::LAYOUT_SPLIT);

    // index of the last point in use, count clamped to the table
    assign count_ext = NW'(count_reg);

    always_comb begin
        if (mode.const_mode || (count_ext == '0)) begin
            last_idx = '0;
        end else if (count_ext > NW'(MAX_POINTS)) begin
            last_idx = IDX_W'(MAX_POINTS - 1);
        end else begin
            last_idx = IDX_W'(count_ext - NW'(1));
        end
    end

    pwl_sequencer u_sequencer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .op      (op)
    );

    pwl_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .op               (op),
        .flags            (flags),
        .mode             (mode),
        .last_idx         (last_idx),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_point_index    (s_point_index),
        .s_point_position (s_point_position),
        .s_left_scale     (s_left_scale),
        .s_right_scale    (s_right_scale),
        .s_sample         (s_sample),
        .s_row_end        (s_row_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_scale_value    (m_scale_value)
    );

endmodule

[src/pwl_checker.sv]
// ----------------------------------------------------------------------------
// pwl_checker
// Port-level checks of the piecewise linear scale block, attached to the
// top level by a bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pwl_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               s_operation,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [pwl_pkg::VALUE_W-1:0] m_scale_value
);

    // a stalled result stays put
    `ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_scale_value))

    // an evaluate transaction keeps the block busy the next cycle
    `ASSERT_NEXT(a_eval_busy, aclk, aresetn, s_valid && s_ready && s_operation, !s_ready)

    // a load transaction never takes the block out of idle
    `ASSERT_NEXT(a_load_no_stall, aclk, aresetn, s_valid && s_ready && !s_operation, s_ready)

    // no result can appear right after an evaluate is taken
    `ASSERT_NEXT(a_no_instant_result, aclk, aresetn, s_valid && s_ready && s_operation, !$rose(m_valid))

    // idle is only reentered with a result on the output
    `ASSERT_SAME(a_ready_no_rise, aclk, aresetn, s_ready && !$past(s_ready) && aresetn && $past(aresetn), m_valid)

endmodule

bind piecewise_linear_scale_function pwl_checker u_pwl_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_operation   (s_operation),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_scale_value (m_scale_value)
);
